// ===== rtl/fpba_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types of the fit-policy allocator.
package fpba_pkg;

    // Fixed field widths of the item, result and configuration beats
    localparam int KIND_W     = 1;
    localparam int BIDX_W     = 4;
    localparam int SIZE_W     = 16;
    localparam int BCNT_W     = 5;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [BCNT_W-1:0] BCNT_RESET = 5'd16;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_BEST  = 2'd0,
        MODE_WORST = 2'd1,
        MODE_FIRST = 2'd2,
        MODE_NEXT  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY_MODE = 1'b0,
        CFG_BLOCK_COUNT = 1'b1
    } t_cfg_idx;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the incoming item beat
        logic load_wr;   // write a loaded size into the table
        logic scan_rd;   // issue one table read of the scan
        logic commit;    // write back the reduced size, form the result
        logic push;      // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_is_load;  // incoming beat is a load
        logic count_zero;  // no block in use
        logic scan_last;   // this read is the last of the scan
        logic out_free;    // output register can take a result
    } t_dp_sts;

endpackage

// ===== rtl/fpba_in_if.sv =====
// Item channel of the fit-policy allocator: valid/ready with the item payload.
interface fpba_in_if;
    import fpba_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BIDX_W-1:0] block_index;
    logic [SIZE_W-1:0] size_value;

    modport source (output valid, output kind, output block_index, output size_value,
                    input ready);
    modport sink   (input valid, input kind, input block_index, input size_value,
                    output ready);
endinterface

// ===== rtl/fpba_out_if.sv =====
// Result channel of the fit-policy allocator: valid/ready with the result payload.
interface fpba_out_if;
    import fpba_pkg::*;

    logic              valid;
    logic              ready;
    logic              granted;
    logic [BIDX_W-1:0] block_number;
    logic [SIZE_W-1:0] remaining_size;

    modport source (output valid, output granted, output block_number, output remaining_size,
                    input ready);
    modport sink   (input valid, input granted, input block_number, input remaining_size,
                    output ready);
endinterface

// ===== rtl/fpba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/fpba_ctrl.sv =====
// Controller state machine of the fit-policy allocator: sequences load, scan and result.
module fpba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fpba_pkg::t_dp_sts i_sts,
    output fpba_pkg::t_dp_cmd o_cmd
);
    import fpba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.in_is_load) begin
                        n_state = S_LOAD;
                    end else if (i_sts.count_zero) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_LOAD:   n_state = S_RESULT;
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_COMMIT;
            S_COMMIT: n_state = S_RESULT;
            S_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Command decode
    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.load_wr = (r_state == S_LOAD);
        o_cmd.scan_rd = (r_state == S_SCAN);
        o_cmd.commit  = (r_state == S_COMMIT);
        o_cmd.push    = (r_state == S_RESULT) && i_sts.out_free;
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== rtl/fpba_dp.sv =====
// Datapath of the fit-policy allocator: configuration, free-size table, scan compare, result.
module fpba_dp #(
    parameter int NBLOCKS   = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [fpba_pkg::KIND_W-1:0]         i_kind,
    input  logic [fpba_pkg::BIDX_W-1:0]         i_block_index,
    input  logic [fpba_pkg::SIZE_W-1:0]         i_size_value,
    input  fpba_pkg::t_dp_cmd                   i_cmd,
    output fpba_pkg::t_dp_sts                   o_sts,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_granted,
    output logic [fpba_pkg::BIDX_W-1:0]         o_block_number,
    output logic [fpba_pkg::SIZE_W-1:0]         o_remaining_size
);
    import fpba_pkg::*;

    localparam int IDX_W = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;

    // Configuration
    t_mode             r_mode;
    logic [BCNT_W-1:0] r_bcount;
    logic [BCNT_W-1:0] count_eff;

    // Item and scan state
    logic [KIND_W-1:0]    r_kind;
    logic [BIDX_W-1:0]    r_bidx;
    logic [SIZE_BITS-1:0] r_size;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     n_idx;
    logic [BCNT_W-1:0]    r_left;
    logic [IDX_W-1:0]     r_start;
    logic [IDX_W-1:0]     start_idx;
    logic [IDX_W-1:0]     r_ptr;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_pick;
    logic [SIZE_BITS-1:0] r_pick_size;

    // Result staging and output register
    logic              r_res_grant;
    logic [BIDX_W-1:0] r_res_num;
    logic [SIZE_W-1:0] r_res_rem;
    logic              r_out_vld;
    logic              r_out_grant;
    logic [BIDX_W-1:0] r_out_num;
    logic [SIZE_W-1:0] r_out_rem;

    // Table port
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic [SIZE_BITS-1:0] rd_data;
    logic [SIZE_BITS-1:0] rem_size;
    logic                 load_ok;
    logic                 fits;
    logic                 better;
    logic                 take;

    // Effective block count is capped at the table depth
    assign count_eff = (32'(r_bcount) > NBLOCKS) ? BCNT_W'(NBLOCKS) : r_bcount;

    // Next fit resumes at the kept pointer unless it went stale
    assign start_idx = ((r_mode == MODE_NEXT) && (32'(r_ptr) < 32'(count_eff))) ? r_ptr : '0;

    // Circular step through the blocks in use
    assign n_idx = ((32'(r_idx) + 32'd1) == 32'(count_eff)) ? '0 : r_idx + IDX_W'(1);

    assign load_ok  = (32'(r_bidx) < 32'(count_eff));
    assign rem_size = r_pick_size - r_size;

    // Candidate ranking; scan order keeps ties on the earliest block
    always_comb begin
        fits = (rd_data >= r_size);
        case (r_mode)
            MODE_BEST:  better = !r_found || (rd_data < r_pick_size);
            MODE_WORST: better = !r_found || (rd_data > r_pick_size);
            default:    better = !r_found;
        endcase
        take = r_rd_vld && fits && better;
    end

    // Table write: load beat or commit of a granted request
    always_comb begin
        ram_we    = (i_cmd.load_wr && load_ok) || (i_cmd.commit && r_found);
        ram_waddr = i_cmd.commit ? r_pick : IDX_W'(r_bidx);
        ram_wdata = i_cmd.commit ? rem_size : r_size;
    end

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NBLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    // Status to the controller
    always_comb begin
        o_sts            = '0;
        o_sts.in_is_load = (i_kind == KIND_LOAD);
        o_sts.count_zero = (count_eff == '0);
        o_sts.scan_last  = (r_left == BCNT_W'(1));
        o_sts.out_free   = !r_out_vld || i_out_ready;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_BEST;
            r_bcount  <= BCNT_RESET;
            r_ptr     <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_POLICY_MODE: r_mode   <= t_mode'(i_cfg_data[MODE_W-1:0]);
                    CFG_BLOCK_COUNT: r_bcount <= i_cfg_data[BCNT_W-1:0];
                    default:         r_bcount <= r_bcount;
                endcase
            end
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.capture) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit && (r_mode == MODE_NEXT)) begin
                r_ptr <= r_found ? r_pick : r_start;
            end
            if (i_cmd.push) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind      <= i_kind;
            r_bidx      <= i_block_index;
            r_size      <= SIZE_BITS'(i_size_value);
            r_idx       <= start_idx;
            r_start     <= start_idx;
            r_left      <= count_eff;
            r_res_grant <= 1'b0;
            r_res_num   <= '0;
            r_res_rem   <= '0;
        end else if (i_cmd.scan_rd) begin
            r_idx  <= n_idx;
            r_left <= r_left - BCNT_W'(1);
        end
        r_rd_idx <= r_idx;
        if (take) begin
            r_pick      <= r_rd_idx;
            r_pick_size <= rd_data;
        end
        if (i_cmd.commit && r_found && (r_kind == KIND_REQUEST)) begin
            r_res_grant <= 1'b1;
            r_res_num   <= BIDX_W'(r_pick);
            r_res_rem   <= SIZE_W'(rem_size);
        end
        if (i_cmd.push) begin
            r_out_grant <= r_res_grant;
            r_out_num   <= r_res_num;
            r_out_rem   <= r_res_rem;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_granted        = r_out_grant;
    assign o_block_number   = r_out_num;
    assign o_remaining_size = r_out_rem;

`ifndef SYNTHESIS
    // The table is never written while a scan read is in flight
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !r_rd_vld)
        else $error("table written during scan");

    // A result is pushed only when the output register can take it
    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> o_sts.out_free)
        else $error("result pushed over a held beat");

    // Scan reads stay inside the blocks in use
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (32'(r_rd_idx) < 32'(count_eff)))
        else $error("scan read beyond block count");

    // A committed grant never underflows the chosen block
    a_commit_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_found) |-> (r_pick_size >= r_size))
        else $error("commit on a block that does not fit");

    // The next-fit pointer stays inside the table
    a_ptr_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (32'(r_ptr) < NBLOCKS))
        else $error("scan pointer beyond table");
`endif
endmodule

// ===== rtl/fit_policy_block_allocator.sv =====
// Fit-policy block allocator: keeps a table of free sizes for up to NBLOCKS blocks in a
// single RAM. A load beat writes one block's free size (ignored when its index is not below
// min(block_count, NBLOCKS)). A request beat scans the blocks in use one RAM read per cycle
// through the one read port of the table and picks one by policy_mode (best, worst, first or
// next fit), subtracts the request and returns granted, block number and remaining size. When
// no block is in use, the scan is skipped and no grant is returned. The result waits in an
// output register, and one item is worked at a time.
module fit_policy_block_allocator #(
    parameter int NBLOCKS   = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fpba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    fpba_in_if.sink                         i_in,
    fpba_out_if.source                      o_out
);
    import fpba_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    fpba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fpba_dp #(
        .NBLOCKS   (NBLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_in.kind),
        .i_block_index    (i_in.block_index),
        .i_size_value     (i_in.size_value),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_granted        (o_out.granted),
        .o_block_number   (o_out.block_number),
        .o_remaining_size (o_out.remaining_size)
    );

    assign i_in.ready = in_ready;
endmodule
